>>> design/tpi_pkg.sv
// Shared types, constants and sine table for the turtle path interpreter.
package tpi_pkg;

   // Defaults for top-level parameters
   localparam int STACK_DEPTH_DEFAULT = 64;

   // Arithmetic setup
   localparam int PALETTE_SIZE = 6;
   localparam int FRAC_BITS    = 8;
   localparam int TRIG_BITS    = 16;
   localparam int TRIG_SHIFT   = TRIG_BITS - FRAC_BITS;
   localparam int ROUND_BIAS   = (TRIG_SHIFT > 0) ? (1 << (TRIG_SHIFT - 1)) : 0;
   localparam int TRIG_W       = TRIG_BITS + 2;      // signed, +/- 1.0 in Q1.16
   localparam int PROD_W       = TRIG_W + 9;         // signed 9-bit step times trig
   localparam int POS_W        = 32;
   localparam int HDG_W        = 9;
   localparam int PAL_W        = 3;

   // Command characters
   localparam logic [7:0] SYM_F      = 8'h46;  // 'F'
   localparam logic [7:0] SYM_G      = 8'h47;  // 'G'
   localparam logic [7:0] SYM_PLUS   = 8'h2B;  // '+'
   localparam logic [7:0] SYM_MINUS  = 8'h2D;  // '-'
   localparam logic [7:0] SYM_GT     = 8'h3E;  // '>'
   localparam logic [7:0] SYM_LBRACK = 8'h5B;  // '['
   localparam logic [7:0] SYM_RBRACK = 8'h5D;  // ']'

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_LENGTH = 2'd1;
   localparam logic [7:0] ANGLE_STEP_RESET  = 8'd60;
   localparam logic [7:0] STEP_LENGTH_RESET = 8'd10;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MOVE,
      OP_TURN_LEFT,
      OP_TURN_RIGHT,
      OP_COLOR,
      OP_PUSH,
      OP_POP
   } op_type;

   typedef enum logic [1:0] {
      ST_SEGMENT   = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic push_ok;
      logic overflow;
      logic pop_ok;
      logic underflow;
   } stack_flags_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_x;
      logic [PAL_W-1:0] palette;
      logic [HDG_W-1:0] heading;
   } stack_entry_type;

   typedef struct packed {
      logic [POS_W-1:0] start_x;
      logic [POS_W-1:0] start_y;
      logic [POS_W-1:0] end_x;
      logic [POS_W-1:0] end_y;
      logic [PAL_W-1:0] color_index;
      status_type       status;
   } result_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic op_type decode_symbol(input logic [7:0] sym);
      op_type op;
      op = OP_NONE;
      if (sym inside {SYM_F, SYM_G}) begin
         op = OP_MOVE;
      end else begin
         case (sym)
            SYM_PLUS:   op = OP_TURN_LEFT;
            SYM_MINUS:  op = OP_TURN_RIGHT;
            SYM_GT:     op = OP_COLOR;
            SYM_LBRACK: op = OP_PUSH;
            SYM_RBRACK: op = OP_POP;
            default:    op = OP_NONE;
         endcase
      end
      return op;
   endfunction

   // Quarter-wave sine table, built at elaboration: Q30 Taylor series to x^17,
   // each term truncated, then rounded to Q16.
   typedef logic [TRIG_BITS:0] qsin_rom_type [0:90];

   function automatic logic [TRIG_BITS:0] quarter_sin(input int unsigned d);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      int                 k;
      x    = (64'(d) * 64'd3373259426 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - signed'(term);
         else            sum = sum + signed'(term);
      end
      if (sum < 0) sum = '0;
      return (TRIG_BITS + 1)'((64'(sum) + 64'd8192) >> 14);
   endfunction

   function automatic qsin_rom_type build_qsin_rom();
      qsin_rom_type rom;
      for (int d = 0; d <= 90; d++) begin
         rom[d] = quarter_sin(d);
      end
      return rom;
   endfunction

   localparam qsin_rom_type QSIN_ROM = build_qsin_rom();

   // sin(h) for h in 0..359, Q1.16 signed
   function automatic logic signed [TRIG_W-1:0] trig_lookup(input logic [HDG_W-1:0] h);
      logic [6:0]              idx;
      logic                    neg;
      logic signed [TRIG_W-1:0] mag;
      if (h <= 9'd90) begin
         idx = 7'(h);
         neg = 1'b0;
      end else if (h <= 9'd180) begin
         idx = 7'(9'd180 - h);
         neg = 1'b0;
      end else if (h <= 9'd270) begin
         idx = 7'(h - 9'd180);
         neg = 1'b1;
      end else begin
         idx = 7'(9'd360 - h);
         neg = 1'b1;
      end
      mag = signed'({1'b0, QSIN_ROM[idx]});
      return neg ? -mag : mag;
   endfunction

   // step * trig rounded to FRAC_BITS, ties up
   function automatic logic [POS_W-1:0] round_delta(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] biased;
      biased = (PROD_W + 1)'(p) + (PROD_W + 1)'(ROUND_BIAS);
      return POS_W'(biased >>> TRIG_SHIFT);
   endfunction

   // value below 720 taken modulo 360
   function automatic logic [HDG_W-1:0] wrap360(input logic [HDG_W:0] v);
      return (v >= 10'd360) ? HDG_W'(v - 10'd360) : HDG_W'(v);
   endfunction

   function automatic logic [PAL_W-1:0] palette_mod(input logic [PAL_W-1:0] v);
      logic [PAL_W:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 8; i++) begin
         if (r >= (PAL_W + 1)'(PALETTE_SIZE)) r = r - (PAL_W + 1)'(PALETTE_SIZE);
      end
      return PAL_W'(r);
   endfunction

endpackage

>>> design/tpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpi_ram
   import tpi_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = addr_width(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tpi_stack.sv
// Branch stack: depth counter, push/pop checks, stack RAMs and write-to-read bypass.
module tpi_stack
   import tpi_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   localparam int ADDR_W = addr_width(STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  op_type            req_op,
   input  logic              req_restart,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  stack_entry_type   wr_entry,
   output stack_flags_type   issue_flags,
   output logic [ADDR_W-1:0] issue_addr,
   output stack_entry_type   pop_entry
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cnt_eff, cnt_dec;
   logic             fwd_sel_ff, fwd_sel_in;
   stack_entry_type  fwd_entry_ff;
   logic             rd_en;
   logic [2*POS_W-1:0]       pos_rd;
   logic [PAL_W+HDG_W-1:0]   hdg_rd;

   always_comb begin
      cnt_eff = req_restart ? '0 : count_ff;
      cnt_dec = cnt_eff - CNT_W'(1);
      issue_flags.push_ok   = (req_op == OP_PUSH) && (cnt_eff < CNT_W'(STACK_DEPTH));
      issue_flags.overflow  = (req_op == OP_PUSH) && !(cnt_eff < CNT_W'(STACK_DEPTH));
      issue_flags.pop_ok    = (req_op == OP_POP) && (cnt_eff != '0);
      issue_flags.underflow = (req_op == OP_POP) && (cnt_eff == '0);
      issue_addr = issue_flags.push_ok ? cnt_eff[ADDR_W-1:0] : cnt_dec[ADDR_W-1:0];

      count_in = count_ff;
      if (accept) begin
         if (issue_flags.push_ok)     count_in = cnt_eff + CNT_W'(1);
         else if (issue_flags.pop_ok) count_in = cnt_dec;
         else                         count_in = cnt_eff;
      end

      rd_en = accept && issue_flags.pop_ok;
      // push still in execute writes the entry this pop reads
      fwd_sel_in = fwd_sel_ff;
      if (accept) fwd_sel_in = wr_en && (wr_addr == issue_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         fwd_sel_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         fwd_sel_ff <= fwd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) fwd_entry_ff <= wr_entry;
   end

   tpi_ram #(
      .WIDTH (2 * POS_W),
      .DEPTH (STACK_DEPTH)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_entry.pos_y, wr_entry.pos_x}),
      .rd_en   (rd_en),
      .rd_addr (issue_addr),
      .rd_data (pos_rd)
   );

   tpi_ram #(
      .WIDTH (PAL_W + HDG_W),
      .DEPTH (STACK_DEPTH)
   ) u_hdg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({wr_entry.palette, wr_entry.heading}),
      .rd_en   (rd_en),
      .rd_addr (issue_addr),
      .rd_data (hdg_rd)
   );

   assign pop_entry = fwd_sel_ff ? fwd_entry_ff : stack_entry_type'({pos_rd, hdg_rd});

endmodule

>>> design/tpi_exec.sv
// Execute stage: turtle registers, move arithmetic, turns, palette and pop restore.
module tpi_exec
   import tpi_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   localparam int ADDR_W = addr_width(STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  op_type            req_op,
   input  logic              req_restart,
   input  stack_flags_type   issue_flags,
   input  logic [ADDR_W-1:0] issue_addr,
   input  stack_entry_type   pop_entry,
   input  logic [7:0]        angle_step,
   input  logic [7:0]        step_length,
   input  logic              out_free,
   output logic              busy,
   output logic              result_valid,
   output result_type        result,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output stack_entry_type   wr_entry
);

   logic              ex_valid_ff, ex_valid_in;
   op_type            ex_op_ff;
   logic              ex_restart_ff;
   stack_flags_type   ex_flags_ff;
   logic [ADDR_W-1:0] ex_addr_ff;

   logic [POS_W-1:0] pos_x_ff, pos_x_in;
   logic [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [HDG_W-1:0] heading_ff, heading_in;
   logic [PAL_W-1:0] palette_ff, palette_in;

   logic [POS_W-1:0] eff_x, eff_y;
   logic [HDG_W-1:0] eff_hdg, cos_hdg;
   logic [PAL_W-1:0] eff_pal;
   logic signed [TRIG_W-1:0] cos_val, sin_val;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic [POS_W-1:0] end_x, end_y;
   logic             has_result, advance;

   always_comb begin
      eff_x   = ex_restart_ff ? '0 : pos_x_ff;
      eff_y   = ex_restart_ff ? '0 : pos_y_ff;
      eff_hdg = ex_restart_ff ? '0 : heading_ff;
      eff_pal = ex_restart_ff ? '0 : palette_ff;

      cos_hdg = wrap360({1'b0, eff_hdg} + 10'd90);
      cos_val = trig_lookup(cos_hdg);
      sin_val = trig_lookup(eff_hdg);
      prod_x  = signed'({1'b0, step_length}) * cos_val;
      prod_y  = signed'({1'b0, step_length}) * sin_val;
      end_x   = eff_x + round_delta(prod_x);
      end_y   = eff_y + round_delta(prod_y);

      pos_x_in   = eff_x;
      pos_y_in   = eff_y;
      heading_in = eff_hdg;
      palette_in = eff_pal;
      case (ex_op_ff)
         OP_MOVE: begin
            pos_x_in = end_x;
            pos_y_in = end_y;
         end
         OP_TURN_LEFT:  heading_in = wrap360({1'b0, eff_hdg} + 10'd360 - {2'b00, angle_step});
         OP_TURN_RIGHT: heading_in = wrap360({1'b0, eff_hdg} + {2'b00, angle_step});
         OP_COLOR: begin
            palette_in = ({1'b0, eff_pal} + 4'd1 == (PAL_W + 1)'(PALETTE_SIZE)) ?
                         '0 : eff_pal + PAL_W'(1);
         end
         OP_POP: begin
            if (ex_flags_ff.pop_ok) begin
               pos_x_in   = pop_entry.pos_x;
               pos_y_in   = pop_entry.pos_y;
               heading_in = wrap360({1'b0, pop_entry.heading});
               palette_in = palette_mod(pop_entry.palette);
            end
         end
         default: ;
      endcase

      has_result = (ex_op_ff == OP_MOVE) || ex_flags_ff.overflow || ex_flags_ff.underflow;
      advance    = ex_valid_ff && (!has_result || out_free);
      busy       = ex_valid_ff && !advance;

      ex_valid_in = ex_valid_ff;
      if (accept)       ex_valid_in = 1'b1;
      else if (advance) ex_valid_in = 1'b0;

      result_valid       = advance && has_result;
      result.start_x     = eff_x;
      result.start_y     = eff_y;
      result.end_x       = (ex_op_ff == OP_MOVE) ? end_x : eff_x;
      result.end_y       = (ex_op_ff == OP_MOVE) ? end_y : eff_y;
      result.color_index = eff_pal;
      if (ex_flags_ff.overflow)       result.status = ST_OVERFLOW;
      else if (ex_flags_ff.underflow) result.status = ST_UNDERFLOW;
      else                            result.status = ST_SEGMENT;

      wr_en            = advance && ex_flags_ff.push_ok;
      wr_addr          = ex_addr_ff;
      wr_entry.pos_x   = eff_x;
      wr_entry.pos_y   = eff_y;
      wr_entry.heading = eff_hdg;
      wr_entry.palette = eff_pal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         heading_ff  <= '0;
         palette_ff  <= '0;
      end else begin
         ex_valid_ff <= ex_valid_in;
         if (advance) begin
            pos_x_ff   <= pos_x_in;
            pos_y_ff   <= pos_y_in;
            heading_ff <= heading_in;
            palette_ff <= palette_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_op_ff    <= OP_NONE;
         ex_flags_ff <= '0;
      end else if (accept) begin
         ex_op_ff    <= req_op;
         ex_flags_ff <= issue_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_restart_ff <= req_restart;
         ex_addr_ff    <= issue_addr;
      end
   end

endmodule

>>> design/turtle_path_interpreter_core.sv
// Top level of the turtle path interpreter: decode, config registers, result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   req     | in        | req_valid/req_stall | req_symbol, req_restart
//   rsp     | out       | rsp_valid/rsp_stall | rsp_start_x/y, rsp_end_x/y,
//           |           |                     | rsp_color_index, rsp_status
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One symbol per cycle sustained while req_stall stays low. An accepted transaction is
// registered into execute, and its result (if any) is then registered into the rsp register.
// The execute stage updates the turtle registers as each symbol advances; a pop reads the
// stack RAM (registered read) at acceptance, and a pop right after a push is bypassed.
// Reset is synchronous; the stack RAMs are not cleared (only pushed entries are read).
// req_stall rises only when execute holds a result-producing symbol and the rsp
// register is full and stalled.
module turtle_path_interpreter_core
   import tpi_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // symbol transactions
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_symbol,
   input  logic                   req_restart,
   // segment / error transactions
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [POS_W-1:0] rsp_start_x,
   output logic signed [POS_W-1:0] rsp_start_y,
   output logic signed [POS_W-1:0] rsp_end_x,
   output logic signed [POS_W-1:0] rsp_end_y,
   output logic [PAL_W-1:0]       rsp_color_index,
   output logic [1:0]             rsp_status,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int ADDR_W = addr_width(STACK_DEPTH);

   logic              accept;
   op_type            req_op;
   stack_flags_type   issue_flags;
   logic [ADDR_W-1:0] issue_addr;
   stack_entry_type   pop_entry;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   stack_entry_type   wr_entry;
   logic              exec_busy;
   logic              result_valid;
   result_type        result;
   logic              out_free;

   logic [7:0]  angle_step_ff, angle_step_in;
   logic [7:0]  step_length_ff, step_length_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   assign req_op    = decode_symbol(req_symbol);
   assign req_stall = exec_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Config writes must come only while idle (not enforced here); no back-pressure
   assign csr_ready = 1'b1;

   always_comb begin
      angle_step_in  = angle_step_ff;
      step_length_in = step_length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANGLE_STEP:  angle_step_in  = csr_data;
            CSR_STEP_LENGTH: step_length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_step_ff  <= ANGLE_STEP_RESET;
         step_length_ff <= STEP_LENGTH_RESET;
      end else begin
         angle_step_ff  <= angle_step_in;
         step_length_ff <= step_length_in;
      end
   end

   tpi_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_op      (req_op),
      .req_restart (req_restart),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_entry    (wr_entry),
      .issue_flags (issue_flags),
      .issue_addr  (issue_addr),
      .pop_entry   (pop_entry)
   );

   tpi_exec #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_op       (req_op),
      .req_restart  (req_restart),
      .issue_flags  (issue_flags),
      .issue_addr   (issue_addr),
      .pop_entry    (pop_entry),
      .angle_step   (angle_step_ff),
      .step_length  (step_length_ff),
      .out_free     (out_free),
      .busy         (exec_busy),
      .result_valid (result_valid),
      .result       (result),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_entry     (wr_entry)
   );

   // Result register: holds while the consumer stalls
   assign rsp_valid_in = result_valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (result_valid) rsp_data_ff <= result;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_x     = rsp_data_ff.start_x;
   assign rsp_start_y     = rsp_data_ff.start_y;
   assign rsp_end_x       = rsp_data_ff.end_x;
   assign rsp_end_y       = rsp_data_ff.end_y;
   assign rsp_color_index = rsp_data_ff.color_index;
   assign rsp_status      = rsp_data_ff.status;

endmodule

>>> design/tpi_checker.sv
// Port-level checks for the turtle path interpreter, bound to the top level.
module tpi_checker
   import tpi_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [7:0]              req_symbol,
   input logic                    req_restart,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [POS_W-1:0] rsp_start_x,
   input logic signed [POS_W-1:0] rsp_start_y,
   input logic signed [POS_W-1:0] rsp_end_x,
   input logic signed [POS_W-1:0] rsp_end_y,
   input logic [PAL_W-1:0]        rsp_color_index,
   input logic [1:0]              rsp_status,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input logic [CSR_INDEX_W-1:0]  csr_index,
   input logic [7:0]              csr_data
);

   // input side only backs up behind a held, stalled result
   a_stall_needs_full_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result transaction");

   // stack errors leave the turtle where it stands
   a_error_no_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SEGMENT) |->
         (rsp_start_x == rsp_end_x && rsp_start_y == rsp_end_y))
      else $error("stack error transaction shows a move");

   a_color_in_palette: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_color_index} < (PAL_W + 1)'(PALETTE_SIZE)))
      else $error("color index outside palette");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_start_x) && $stable(rsp_start_y) &&
          $stable(rsp_end_x) && $stable(rsp_end_y) &&
          $stable(rsp_color_index) && $stable(rsp_status)))
      else $error("stalled result transaction changed");

endmodule

bind turtle_path_interpreter_core tpi_checker u_tpi_checker (.*);
